FILE: hdl/gwr_pkg.sv
package gwr_pkg;

	// Cell coordinates travel as 3-bit fields, so the grid array is fixed at 8 by 8.
	localparam int GRID_DEF = 8;
	localparam logic [3:0] SIZE_RESET = 4'd7;

	typedef enum logic {
		ACT_WRITE = 1'b0,
		ACT_ROUTE = 1'b1
	} action_t;

	// Controller commands to the datapath.
	typedef struct packed {
		logic load;      // capture the request fields
		logic cell_wr;   // apply a cell write
		logic seed;      // start wave: seed the front with the goal
		logic step;      // test the front against the mover, else grow it
		logic commit;    // update occupancy, load the result
	} cmd_t;

	// Datapath status back to the controller.
	typedef struct packed {
		logic is_route;
		logic start_ok;
		logic hit;
		logic front_empty;
	} stat_t;

endpackage

FILE: hdl/gwr_ctrl.sv
module gwr_ctrl
	import gwr_pkg::*;
(
	input  logic  clk,
	input  logic  arst_n,
	input  logic  in_fire,
	input  logic  out_busy,
	input  stat_t st,
	output logic  in_rdy,
	output cmd_t  cmd
);

	typedef enum logic [1:0] {
		S_IDLE,
		S_DISPATCH,
		S_WAVE,
		S_COMMIT
	} state_t;

	state_t state_q;

	assign in_rdy = (state_q == S_IDLE);

	always_comb begin
		cmd = '0;
		cmd.load = in_fire;
		case (state_q)
			S_DISPATCH: begin
				cmd.cell_wr = !st.is_route;
				cmd.seed    = st.is_route && st.start_ok;
			end
			S_WAVE:   cmd.step = 1'b1;
			S_COMMIT: cmd.commit = !out_busy;
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			case (state_q)
				S_IDLE: if (in_fire) state_q <= S_DISPATCH;
				S_DISPATCH: begin
					if (!st.is_route) state_q <= S_IDLE;
					else if (st.start_ok) state_q <= S_WAVE;
					else state_q <= S_COMMIT;
				end
				S_WAVE: if (st.hit || st.front_empty) state_q <= S_COMMIT;
				S_COMMIT: if (!out_busy) state_q <= S_IDLE;
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_COMMIT && !out_busy) |=> state_q == S_IDLE)
		else $error("commit did not return to idle");
	assert property (@(posedge clk) disable iff (!arst_n)
		in_fire |-> state_q == S_IDLE)
		else $error("request taken while busy");
	assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0({cmd.cell_wr, cmd.seed, cmd.step, cmd.commit}))
		else $error("conflicting commands");

endmodule

FILE: hdl/gwr_dp.sv
module gwr_dp
	import gwr_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic [3:0] size_q,
	input  cmd_t       cmd,
	input  logic       in_action,
	input  logic [2:0] in_cell_row,
	input  logic [2:0] in_cell_col,
	input  logic       in_cell_blocked,
	input  logic [2:0] in_goal_row,
	input  logic [2:0] in_goal_col,
	input  logic [2:0] in_mover_row,
	input  logic [2:0] in_mover_col,
	output stat_t      st,
	output logic       res_load,
	output logic [2:0] res_row,
	output logic [2:0] res_col,
	output logic       res_moved
);

	localparam int CELLS = GRID_DEF * GRID_DEF;
	localparam int IW = $clog2(CELLS);

	function automatic logic [CELLS-1:0] col_mask(int col);
		logic [CELLS-1:0] m;
		int i;
		m = '0;
		for (i = 0; i < CELLS; i++)
			if (i % GRID_DEF == col) m[i] = 1'b1;
		return m;
	endfunction

	function automatic logic [IW-1:0] cidx(logic [2:0] r, logic [2:0] c);
		return IW'(r) * IW'(GRID_DEF) + IW'(c);
	endfunction

	// Stop sideways shifts of the front from wrapping into the next row.
	localparam logic [CELLS-1:0] COL_FIRST = col_mask(0);
	localparam logic [CELLS-1:0] COL_LAST  = col_mask(GRID_DEF - 1);

	logic [CELLS-1:0] occ_q, occ_d;
	logic [CELLS-1:0] reach_q;    // cells the wave has reached
	logic [CELLS-1:0] front_q;    // cells of the current distance level
	logic             act_q, blk_q;
	logic [2:0]       cr_q, cc_q, gr_q, gc_q, mr_q, mc_q;
	logic [2:0]       br_q, bc_q;
	logic             moved_q;
	logic [4:0]       n;
	logic [CELLS-1:0] act_mask, spread, grow, goal_bit;

	always_comb begin
		if (size_q < 4'd2) n = 5'd2;
		else if ({1'b0, size_q} > 5'(GRID_DEF)) n = 5'(GRID_DEF);
		else n = {1'b0, size_q};
	end

	always_comb begin
		for (int i = 0; i < CELLS; i++)
			act_mask[i] = (5'(i / GRID_DEF) < n) && (5'(i % GRID_DEF) < n);
	end

	logic goal_in, mover_in;
	assign goal_in  = ({2'b0, gr_q} < n) && ({2'b0, gc_q} < n);
	assign mover_in = ({2'b0, mr_q} < n) && ({2'b0, mc_q} < n);

	logic [IW-1:0] gi, mi, ci;
	assign gi = cidx(gr_q, gc_q);
	assign mi = cidx(mr_q, mc_q);
	assign ci = cidx(cr_q, cc_q);
	assign goal_bit = CELLS'(1) << gi;

	// Next distance level: free, active, unreached neighbours of the front.
	assign spread = (front_q << GRID_DEF) | (front_q >> GRID_DEF)
		| ((front_q << 1) & ~COL_FIRST) | ((front_q >> 1) & ~COL_LAST);
	assign grow = spread & ~reach_q & ~occ_q & act_mask;

	// Mover neighbours on the current level, in the order up, right, down, left.
	logic [2:0] up_r, dn_r, rt_c, lf_c, pick_r, pick_c;
	logic [3:0] nb_hit;
	assign up_r = mr_q - 3'd1;
	assign dn_r = mr_q + 3'd1;
	assign rt_c = mc_q + 3'd1;
	assign lf_c = mc_q - 3'd1;
	assign nb_hit[0] = (mr_q != 3'd0) && front_q[cidx(up_r, mc_q)];
	assign nb_hit[1] = (mc_q != 3'(GRID_DEF - 1)) && front_q[cidx(mr_q, rt_c)];
	assign nb_hit[2] = (mr_q != 3'(GRID_DEF - 1)) && front_q[cidx(dn_r, mc_q)];
	assign nb_hit[3] = (mc_q != 3'd0) && front_q[cidx(mr_q, lf_c)];

	always_comb begin
		pick_r = mr_q;
		pick_c = mc_q;
		if (nb_hit[0]) pick_r = up_r;
		else if (nb_hit[1]) pick_c = rt_c;
		else if (nb_hit[2]) pick_r = dn_r;
		else if (nb_hit[3]) pick_c = lf_c;
	end

	always_comb begin
		occ_d = occ_q;
		if (cmd.cell_wr) occ_d[ci] = blk_q;
		if (cmd.commit && mover_in) begin
			occ_d[mi] = 1'b0;
			occ_d[cidx(br_q, bc_q)] = 1'b1;
		end
	end

	assign st.is_route    = act_q;
	assign st.start_ok    = goal_in && mover_in;
	assign st.hit         = |nb_hit;
	assign st.front_empty = (front_q == '0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			occ_q <= '0;
			reach_q <= '0;
			front_q <= '0;
			act_q <= 1'b0;
			blk_q <= 1'b0;
			cr_q <= '0; cc_q <= '0; gr_q <= '0; gc_q <= '0; mr_q <= '0; mc_q <= '0;
			br_q <= '0; bc_q <= '0;
			moved_q <= 1'b0;
			res_load <= 1'b0;
			res_row <= '0;
			res_col <= '0;
			res_moved <= 1'b0;
		end else begin
			occ_q <= occ_d;
			res_load <= cmd.commit;
			if (cmd.load) begin
				act_q <= in_action;
				cr_q <= in_cell_row; cc_q <= in_cell_col; blk_q <= in_cell_blocked;
				gr_q <= in_goal_row; gc_q <= in_goal_col;
				mr_q <= in_mover_row; mc_q <= in_mover_col;
				moved_q <= 1'b0;
				br_q <= in_mover_row; bc_q <= in_mover_col;
			end else if (cmd.step && (|nb_hit)) begin
				moved_q <= 1'b1;
				br_q <= pick_r;
				bc_q <= pick_c;
			end
			if (cmd.seed) begin
				reach_q <= goal_bit;
				front_q <= goal_bit;
			end else if (cmd.step && !(|nb_hit)) begin
				reach_q <= reach_q | grow;
				front_q <= grow;
			end
			if (cmd.commit) begin
				res_row <= br_q;
				res_col <= bc_q;
				res_moved <= moved_q;
			end
		end
	end

	assert property (@(posedge clk) disable iff (!arst_n)
		(front_q & ~reach_q) == '0)
		else $error("front outside reached set");
	assert property (@(posedge clk) disable iff (!arst_n)
		res_load |=> !res_load)
		else $error("result loaded twice");
	assert property (@(posedge clk) disable iff (!arst_n)
		res_load |-> (res_moved || (res_row == mr_q && res_col == mc_q)))
		else $error("unmoved result differs from mover");

endmodule

FILE: hdl/grid_wave_route_step_core.sv
// A cell-write request passes through accept and dispatch, then the block is idle.
// A route request runs dispatch, one wave cycle per distance level until a
// neighbour of the mover is reached or the wave dies out (the wave is skipped
// when goal or mover lie outside), then commit; the result is registered in the
// datapath, then in the output register behind m_tvalid. One request at a time;
// the next is taken the cycle after commit, and a stalled result holds commit.
// Reset (arst_n low, asynchronous): occupancy all free, grid_size 7, idle.
module grid_wave_route_step_core
	import gwr_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic        s_tuser,    // action[0]
	// cell_row[2:0], cell_col[5:3], cell_blocked[6], goal_row[9:7],
	// goal_col[12:10], mover_row[15:13], mover_col[18:16], zero fill to 24
	input  logic [23:0] s_tdata,
	output logic        m_tvalid,
	input  logic        m_tready,
	// next_row[2:0], next_col[5:3], moved[6], zero fill [7]
	output logic [7:0]  m_tdata,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [3:0]  cfg_data
);

	logic [3:0] size_q;
	logic       in_rdy, in_fire;
	cmd_t       cmd;
	stat_t      st;
	logic       res_load, res_moved;
	logic [2:0] res_row, res_col;
	logic       out_v_q;
	logic [7:0] out_q;

	// Always take grid_size writes; the size is only sampled during a request.
	assign cfg_ready = 1'b1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) size_q <= SIZE_RESET;
		else if (cfg_valid) size_q <= cfg_data;
	end

	assign s_tready = in_rdy;
	assign in_fire  = s_tvalid && s_tready;

	gwr_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_fire  (in_fire),
		.out_busy (out_v_q && !m_tready),
		.st       (st),
		.in_rdy   (in_rdy),
		.cmd      (cmd)
	);

	gwr_dp u_dp (
		.clk             (clk),
		.arst_n          (arst_n),
		.size_q          (size_q),
		.cmd             (cmd),
		.in_action       (s_tuser),
		.in_cell_row     (s_tdata[2:0]),
		.in_cell_col     (s_tdata[5:3]),
		.in_cell_blocked (s_tdata[6]),
		.in_goal_row     (s_tdata[9:7]),
		.in_goal_col     (s_tdata[12:10]),
		.in_mover_row    (s_tdata[15:13]),
		.in_mover_col    (s_tdata[18:16]),
		.st              (st),
		.res_load        (res_load),
		.res_row         (res_row),
		.res_col         (res_col),
		.res_moved       (res_moved)
	);

	// Hold the result until the sink takes it.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q <= 1'b0;
		end else if (res_load) begin
			out_v_q <= 1'b1;
			out_q   <= {1'b0, res_moved, res_col, res_row};
		end else if (m_tready) begin
			out_v_q <= 1'b0;
		end
	end

	assign m_tvalid = out_v_q;
	assign m_tdata  = out_q;

	assert property (@(posedge clk) disable iff (!arst_n)
		res_load |-> !(out_v_q && !m_tready))
		else $error("result overwritten");
	assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && !m_tready) |=> m_tvalid && $stable(m_tdata))
		else $error("stalled result changed");
	assert property (@(posedge clk) disable iff (!arst_n)
		in_fire |=> !s_tready)
		else $error("second request accepted early");

endmodule
